// ----- hdl/sbc_pkg.sv -----
`timescale 1ns / 1ps
// Shared widths, codes and payload types of the sphere/box classifier.
package sbc_pkg;

    // Coordinate and derived arithmetic widths
    localparam int COORD_BITS  = 24;
    localparam int RADIUS_BITS = COORD_BITS - 1;
    localparam int DIFF_BITS   = COORD_BITS + 1;
    localparam int SQ_BITS     = 2 * COORD_BITS;
    localparam int R2_BITS     = 2 * RADIUS_BITS;
    localparam int SUM_BITS    = SQ_BITS + 2;
    localparam int AXES        = 3;
    localparam int CORNERS     = 8;

    // Configuration port
    localparam int CFG_ADDR_BITS = 3;
    localparam int CFG_DATA_BITS = 32;
    localparam logic CFG_IDX_CORNER_EN = 1'b0;

    // Placement codes
    localparam logic [1:0] PLACE_OUTSIDE    = 2'd0;
    localparam logic [1:0] PLACE_INTERSECTS = 2'd1;
    localparam logic [1:0] PLACE_INSIDE     = 2'd2;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic [SQ_BITS-1:0] sq_t;

    // One sphere/box pair, axis 0 is x
    typedef struct packed {
        coord_t [AXES-1:0]      center;
        coord_t [AXES-1:0]      box_min;
        coord_t [AXES-1:0]      box_max;
        logic [RADIUS_BITS-1:0] radius;
    } item_t;

    // Squared per-axis gaps to both faces plus slab position flags
    typedef struct packed {
        sq_t [AXES-1:0]     sq_lo;
        sq_t [AXES-1:0]     sq_hi;
        logic [AXES-1:0]    below;
        logic [AXES-1:0]    above;
        logic [R2_BITS-1:0] r2;
    } sq_word_t;

endpackage

// ----- hdl/sbc_in_if.sv -----
`timescale 1ns / 1ps
// Input channel interface: one sphere/box word with valid/ready.
interface sbc_in_if;
    logic valid;
    logic ready;
    logic signed [sbc_pkg::COORD_BITS-1:0] center_x;
    logic signed [sbc_pkg::COORD_BITS-1:0] center_y;
    logic signed [sbc_pkg::COORD_BITS-1:0] center_z;
    logic [sbc_pkg::RADIUS_BITS-1:0]       radius;
    logic signed [sbc_pkg::COORD_BITS-1:0] box_min_x;
    logic signed [sbc_pkg::COORD_BITS-1:0] box_min_y;
    logic signed [sbc_pkg::COORD_BITS-1:0] box_min_z;
    logic signed [sbc_pkg::COORD_BITS-1:0] box_max_x;
    logic signed [sbc_pkg::COORD_BITS-1:0] box_max_y;
    logic signed [sbc_pkg::COORD_BITS-1:0] box_max_z;

    modport source (
        output valid, center_x, center_y, center_z, radius,
               box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
        input  ready
    );
    modport sink (
        input  valid, center_x, center_y, center_z, radius,
               box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
        output ready
    );
endinterface

// ----- hdl/sbc_out_if.sv -----
`timescale 1ns / 1ps
// Output channel interface: one placement word with valid/ready.
interface sbc_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] placement;

    modport source (output valid, placement, input ready);
    modport sink (input valid, placement, output ready);
endinterface

// ----- hdl/sbc_cfg_regs.sv -----
`timescale 1ns / 1ps
// APB-style configuration register: corner test enable.
module sbc_cfg_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [sbc_pkg::CFG_ADDR_BITS-1:0]  paddr,
    input  logic [sbc_pkg::CFG_DATA_BITS-1:0]  pwdata,
    output logic [sbc_pkg::CFG_DATA_BITS-1:0]  prdata,
    output logic                               pready,
    output logic                               corner_en
);
    logic corner_en_reg;
    logic corner_en_next;
    logic reg_index;
    logic wr_hit;

    assign pready    = 1'b1;
    assign reg_index = paddr[2];
    assign wr_hit    = psel && penable && pwrite && pready
                       && (reg_index == sbc_pkg::CFG_IDX_CORNER_EN);

    // Take the written bit, drop writes to unknown registers
    always_comb
    begin
        corner_en_next = corner_en_reg;
        if (wr_hit)
        begin
            corner_en_next = pwdata[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            corner_en_reg <= 1'b1;
        end
        else
        begin
            corner_en_reg <= corner_en_next;
        end
    end

    // Read back
    always_comb
    begin
        prdata = '0;
        if (reg_index == sbc_pkg::CFG_IDX_CORNER_EN)
        begin
            prdata[0] = corner_en_reg;
        end
    end

    assign corner_en = corner_en_reg;
endmodule

// ----- hdl/sbc_square_stage.sv -----
`timescale 1ns / 1ps
// Square stage: per-axis face distances squared, slab flags and radius squared.
module sbc_square_stage (
    input  logic              clk,
    input  logic              load,
    input  sbc_pkg::item_t    item,
    output sbc_pkg::sq_word_t sq_word
);
    sbc_pkg::sq_word_t sq_word_reg;
    sbc_pkg::sq_word_t sq_word_next;

    // One subtract, magnitude and square per face per axis
    always_comb
    begin
        logic signed [sbc_pkg::DIFF_BITS-1:0] d_lo;
        logic signed [sbc_pkg::DIFF_BITS-1:0] d_hi;
        logic [sbc_pkg::DIFF_BITS-1:0]        m_lo;
        logic [sbc_pkg::DIFF_BITS-1:0]        m_hi;
        logic [sbc_pkg::COORD_BITS-1:0]       a_lo;
        logic [sbc_pkg::COORD_BITS-1:0]       a_hi;
        d_lo = '0;
        d_hi = '0;
        m_lo = '0;
        m_hi = '0;
        a_lo = '0;
        a_hi = '0;
        sq_word_next = '0;
        for (int ax = 0; ax < sbc_pkg::AXES; ax++)
        begin
            d_lo = $signed({item.center[ax][sbc_pkg::COORD_BITS-1], item.center[ax]})
                 - $signed({item.box_min[ax][sbc_pkg::COORD_BITS-1], item.box_min[ax]});
            d_hi = $signed({item.center[ax][sbc_pkg::COORD_BITS-1], item.center[ax]})
                 - $signed({item.box_max[ax][sbc_pkg::COORD_BITS-1], item.box_max[ax]});
            m_lo = d_lo[sbc_pkg::DIFF_BITS-1] ? (~d_lo + 1'b1) : d_lo;
            m_hi = d_hi[sbc_pkg::DIFF_BITS-1] ? (~d_hi + 1'b1) : d_hi;
            // Magnitudes stay below 2^COORD_BITS
            a_lo = m_lo[sbc_pkg::COORD_BITS-1:0];
            a_hi = m_hi[sbc_pkg::COORD_BITS-1:0];
            sq_word_next.sq_lo[ax] = sbc_pkg::SQ_BITS'(a_lo) * sbc_pkg::SQ_BITS'(a_lo);
            sq_word_next.sq_hi[ax] = sbc_pkg::SQ_BITS'(a_hi) * sbc_pkg::SQ_BITS'(a_hi);
            sq_word_next.below[ax] = d_lo[sbc_pkg::DIFF_BITS-1];
            sq_word_next.above[ax] = !d_lo[sbc_pkg::DIFF_BITS-1]
                                     && !d_hi[sbc_pkg::DIFF_BITS-1] && (d_hi != '0);
        end
        sq_word_next.r2 = sbc_pkg::R2_BITS'(item.radius) * sbc_pkg::R2_BITS'(item.radius);
    end

    // Hold unless the next stage makes room
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            sq_word_reg <= sq_word_next;
        end
    end

    assign sq_word = sq_word_reg;
endmodule

// ----- hdl/sbc_decide_stage.sv -----
`timescale 1ns / 1ps
// Decide stage: gap sum and eight corner sums against radius squared.
module sbc_decide_stage (
    input  logic              clk,
    input  logic              load,
    input  logic              corner_en,
    input  sbc_pkg::sq_word_t sq_word,
    output logic [1:0]        placement
);
    logic [1:0]                   placement_reg;
    logic [1:0]                   placement_next;
    logic [sbc_pkg::SUM_BITS-1:0] gap_sum;
    logic [sbc_pkg::SUM_BITS-1:0] r2_ext;
    logic [sbc_pkg::CORNERS-1:0]  corner_far;

    assign r2_ext = sbc_pkg::SUM_BITS'(sq_word.r2);

    // Sum gaps only on axes where the center sits outside the slab
    always_comb
    begin
        gap_sum = '0;
        for (int ax = 0; ax < sbc_pkg::AXES; ax++)
        begin
            if (sq_word.below[ax])
            begin
                gap_sum = gap_sum + sbc_pkg::SUM_BITS'(sq_word.sq_lo[ax]);
            end
            else if (sq_word.above[ax])
            begin
                gap_sum = gap_sum + sbc_pkg::SUM_BITS'(sq_word.sq_hi[ax]);
            end
        end
    end

    // Corner k takes the max face on axis a when bit a of k is set
    always_comb
    begin
        logic [sbc_pkg::SUM_BITS-1:0] csum;
        csum = '0;
        corner_far = '0;
        for (int k = 0; k < sbc_pkg::CORNERS; k++)
        begin
            csum = '0;
            for (int ax = 0; ax < sbc_pkg::AXES; ax++)
            begin
                csum = csum + sbc_pkg::SUM_BITS'(((k >> ax) & 1) != 0
                                                 ? sq_word.sq_hi[ax] : sq_word.sq_lo[ax]);
            end
            corner_far[k] = (csum >= r2_ext);
        end
    end

    always_comb
    begin
        if (gap_sum >= r2_ext)
        begin
            placement_next = sbc_pkg::PLACE_OUTSIDE;
        end
        else if (corner_en && (corner_far != '0))
        begin
            placement_next = sbc_pkg::PLACE_INTERSECTS;
        end
        else
        begin
            placement_next = sbc_pkg::PLACE_INSIDE;
        end
    end

    // Hold the result until the output side takes it
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            placement_reg <= placement_next;
        end
    end

    assign placement = placement_reg;
endmodule

// ----- hdl/sphere_box_classify_unit.sv -----
`timescale 1ns / 1ps
// Top level of the sphere/box classifier: channels, pipeline control, config.
//
//  channel     dir   payload                                   handshake
//  sphere_in   in    center_x/y/z, radius, box_min/max_x/y/z   valid/ready
//  place_out   out   placement (0 outside, 1 intersects, 2 in)  valid/ready
//  apb         in    corner_test_enable at byte address 0      psel/penable, pready=1
//
// Three register stages: input word, squares, result. One word per cycle
// sustained while place_out.ready stays high; place_out.valid rises once the
// word has moved through the input word, squares and result registers.
// The per-axis squares (six of them plus radius squared) are the longest path.
// Each stage loads when it is empty or the stage after it moves, so bubbles
// close up while the output stalls; ready drops only with all three full.
// rst_n clears stage valids and sets corner_test_enable to 1.
module sphere_box_classify_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    sbc_in_if.sink                             sphere_in,
    sbc_out_if.source                          place_out,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [sbc_pkg::CFG_ADDR_BITS-1:0]  paddr,
    input  logic [sbc_pkg::CFG_DATA_BITS-1:0]  pwdata,
    output logic [sbc_pkg::CFG_DATA_BITS-1:0]  prdata,
    output logic                               pready
);
    logic           v0_reg, v1_reg, v2_reg;
    logic           v0_next, v1_next, v2_next;
    logic           ld0, ld1, ld2;
    logic           corner_en;
    sbc_pkg::item_t item_reg;
    sbc_pkg::item_t item_next;
    sbc_pkg::sq_word_t sq_word;

    sbc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .corner_en (corner_en)
    );

    // Stage loads: empty, or the next stage moves
    assign ld2 = !v2_reg || place_out.ready;
    assign ld1 = !v1_reg || ld2;
    assign ld0 = !v0_reg || ld1;
    assign sphere_in.ready = ld0;

    assign v0_next = ld0 ? sphere_in.valid : v0_reg;
    assign v1_next = ld1 ? v0_reg : v1_reg;
    assign v2_next = ld2 ? v1_reg : v2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= v0_next;
            v1_reg <= v1_next;
            v2_reg <= v2_next;
        end
    end

    // Gather the input word
    always_comb
    begin
        item_next.center[0]  = sphere_in.center_x;
        item_next.center[1]  = sphere_in.center_y;
        item_next.center[2]  = sphere_in.center_z;
        item_next.box_min[0] = sphere_in.box_min_x;
        item_next.box_min[1] = sphere_in.box_min_y;
        item_next.box_min[2] = sphere_in.box_min_z;
        item_next.box_max[0] = sphere_in.box_max_x;
        item_next.box_max[1] = sphere_in.box_max_y;
        item_next.box_max[2] = sphere_in.box_max_z;
        item_next.radius     = sphere_in.radius;
    end

    always_ff @(posedge clk)
    begin
        if (ld0 && sphere_in.valid)
        begin
            item_reg <= item_next;
        end
    end

    sbc_square_stage u_square (
        .clk     (clk),
        .load    (ld1 && v0_reg),
        .item    (item_reg),
        .sq_word (sq_word)
    );

    sbc_decide_stage u_decide (
        .clk       (clk),
        .load      (ld2 && v1_reg),
        .corner_en (corner_en),
        .sq_word   (sq_word),
        .placement (place_out.placement)
    );

    assign place_out.valid = v2_reg;

    // Checks
    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        place_out.valid |-> place_out.placement <= sbc_pkg::PLACE_INSIDE)
        else $error("placement code out of range");

    a_fast_mode: assert property (@(posedge clk) disable iff (!rst_n)
        place_out.valid && !corner_en |-> place_out.placement != sbc_pkg::PLACE_INTERSECTS)
        else $error("intersects reported with corner test off");

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !sphere_in.ready |-> v0_reg && v1_reg && v2_reg)
        else $error("input stalled with a free stage");

    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg && v2_reg && !place_out.ready |=> v1_reg && v2_reg)
        else $error("pipeline word lost under stall");
endmodule
